// File: rtl/weighted_3x3_smoothing_filter_assert.svh
// Assertion macros for the weighted 3x3 smoothing filter.
// Taken in by the top level; no other dependencies.
`ifndef WEIGHTED_3X3_SMOOTHING_FILTER_ASSERT_SVH
`define WEIGHTED_3X3_SMOOTHING_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define WSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsf: same-cycle check failed");
`define WSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsf: next-cycle check failed");
`else
`define WSF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/wsf_pkg.sv
// Shared widths, register indexes, reset values and types of the smoothing filter.
// No dependencies.
package wsf_pkg;

    localparam int PIX_W         = 8;
    localparam int ROW_W         = 12;
    localparam int IMG_W_W       = 11;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int SUM_W         = 12;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MIN_SIZE      = 3;

    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = 12'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // sum / 10 as (sum * 6554) >> 16, exact for sums below 16384
    localparam int                   DIV10_MUL_W = 13;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 13'd6554;
    localparam int                   DIV10_SHIFT = 16;

    typedef struct packed {
        logic res_a;
        logic res_b;
        logic res_c;
        logic filt;
        logic done;
    } t_emit;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
    } t_line;

endpackage

// File: rtl/wsf_line_mem.sv
// Line store memory: one entry per column holding the two rows above the current one.
// Depends on wsf_pkg.
module wsf_line_mem #(
    parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [COL_W-1:0]    i_rd_addr,
    output wsf_pkg::t_line      o_rd_data,
    input  logic                i_wr_en,
    input  logic [COL_W-1:0]    i_wr_addr,
    input  wsf_pkg::t_line      i_wr_data
);

    wsf_pkg::t_line r_mem [MAX_WIDTH];
    wsf_pkg::t_line r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/wsf_ctrl.sv
// Configuration registers, raster position counters and the first pipeline stage.
// Depends on wsf_pkg.
module wsf_ctrl #(
    parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wsf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wsf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    input  logic                          i_s1_load,
    input  logic [wsf_pkg::PIX_W-1:0]     i_pixel,
    output logic [COL_W-1:0]              o_rd_addr,
    output logic                          o_s1_valid,
    output logic [wsf_pkg::PIX_W-1:0]     o_s1_px,
    output logic [wsf_pkg::ROW_W-1:0]     o_s1_row,
    output logic [COL_W-1:0]              o_s1_col,
    output wsf_pkg::t_emit                o_s1_emit
);

    localparam int ROW_W = wsf_pkg::ROW_W;
    localparam int CMP_W = (COL_W + 1 > wsf_pkg::IMG_W_W) ? COL_W + 1 : wsf_pkg::IMG_W_W;
    localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] MIN_W_C = CMP_W'(wsf_pkg::MIN_SIZE);
    localparam logic [ROW_W-1:0] MIN_H_C = ROW_W'(wsf_pkg::MIN_SIZE);

    logic [wsf_pkg::IMG_W_W-1:0] r_img_width;
    logic [ROW_W-1:0]            r_img_height;
    logic [COL_W-1:0]            r_col;
    logic [ROW_W-1:0]            r_row;
    logic [COL_W-1:0]            n_col;
    logic [ROW_W-1:0]            n_row;

    logic                        r_s1_valid;
    logic [wsf_pkg::PIX_W-1:0]   r_s1_px;
    logic [ROW_W-1:0]            r_s1_row;
    logic [COL_W-1:0]            r_s1_col;
    wsf_pkg::t_emit              r_s1_emit;
    wsf_pkg::t_emit              n_emit;

    logic [CMP_W-1:0]            width_ext;
    logic [CMP_W-1:0]            w_eff;
    logic [ROW_W-1:0]            h_eff;
    logic [COL_W-1:0]            cur_col;
    logic [ROW_W-1:0]            row_wrap;
    logic [ROW_W-1:0]            cur_row;
    logic [CMP_W-1:0]            col_inc;
    logic [ROW_W-1:0]            row_inc;
    logic                        last_col;

    always_comb begin
        width_ext = CMP_W'(r_img_width);
        if (width_ext < MIN_W_C) begin
            w_eff = MIN_W_C;
        end else if (width_ext > MAX_W_C) begin
            w_eff = MAX_W_C;
        end else begin
            w_eff = width_ext;
        end
        h_eff = (r_img_height < MIN_H_C) ? MIN_H_C : r_img_height;

        // wrap a position left outside a shrunken frame
        if (CMP_W'(r_col) >= w_eff) begin
            cur_col  = '0;
            row_wrap = r_row + 1'b1;
        end else begin
            cur_col  = r_col;
            row_wrap = r_row;
        end
        cur_row = (row_wrap >= h_eff) ? '0 : row_wrap;

        col_inc = CMP_W'(cur_col) + 1'b1;
        row_inc = cur_row + 1'b1;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc;
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = cur_row;
        end

        last_col     = (CMP_W'(cur_col) == w_eff - 1'b1);
        n_emit.res_a = (cur_row != '0) && (cur_col != '0);
        n_emit.res_b = (cur_row != '0) && last_col;
        n_emit.res_c = (cur_row == h_eff - 1'b1);
        n_emit.filt  = (cur_row > ROW_W'(1)) && (cur_col > COL_W'(1));
        n_emit.done  = last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= wsf_pkg::WIDTH_RESET;
            r_img_height <= wsf_pkg::HEIGHT_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    wsf_pkg::REG_IMAGE_WIDTH: begin
                        r_img_width <= i_cfg_data[wsf_pkg::IMG_W_W-1:0];
                    end
                    wsf_pkg::REG_IMAGE_HEIGHT: begin
                        r_img_height <= i_cfg_data[ROW_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_s1_load) begin
                r_s1_valid <= i_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_px   <= i_pixel;
            r_s1_row  <= cur_row;
            r_s1_col  <= cur_col;
            r_s1_emit <= n_emit;
        end
    end

    assign o_rd_addr  = cur_col;
    assign o_s1_valid = r_s1_valid;
    assign o_s1_px    = r_s1_px;
    assign o_s1_row   = r_s1_row;
    assign o_s1_col   = r_s1_col;
    assign o_s1_emit  = r_s1_emit;

endmodule

// File: rtl/wsf_window.sv
// 3x3 window, line store write-back and weighted sum stage.
// Depends on wsf_pkg.
module wsf_window #(
    parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s2_load,
    input  logic                        i_s1_valid,
    input  logic [wsf_pkg::PIX_W-1:0]   i_s1_px,
    input  logic [wsf_pkg::ROW_W-1:0]   i_s1_row,
    input  logic [COL_W-1:0]            i_s1_col,
    input  wsf_pkg::t_emit              i_s1_emit,
    input  wsf_pkg::t_line              i_rd_data,
    output logic                        o_wr_en,
    output logic [COL_W-1:0]            o_wr_addr,
    output wsf_pkg::t_line              o_wr_data,
    output logic                        o_s2_valid,
    output logic [wsf_pkg::SUM_W-1:0]   o_s2_sum,
    output logic [wsf_pkg::PIX_W-1:0]   o_s2_center,
    output logic [wsf_pkg::PIX_W-1:0]   o_s2_mid,
    output logic [wsf_pkg::PIX_W-1:0]   o_s2_px,
    output logic [wsf_pkg::ROW_W-1:0]   o_s2_row,
    output logic [COL_W-1:0]            o_s2_col,
    output wsf_pkg::t_emit              o_s2_emit
);

    localparam int SUM_W = wsf_pkg::SUM_W;

    typedef struct packed {
        logic [wsf_pkg::PIX_W-1:0] top;
        logic [wsf_pkg::PIX_W-1:0] mid;
        logic [wsf_pkg::PIX_W-1:0] bot;
    } t_wcol;

    t_wcol                      r_win_a;
    t_wcol                      r_win_b;
    t_wcol                      new_col;
    logic                       shift;
    logic [SUM_W-1:0]           n_sum;

    logic                       r_s2_valid;
    logic [SUM_W-1:0]           r_s2_sum;
    logic [wsf_pkg::PIX_W-1:0]  r_s2_center;
    logic [wsf_pkg::PIX_W-1:0]  r_s2_mid;
    logic [wsf_pkg::PIX_W-1:0]  r_s2_px;
    logic [wsf_pkg::ROW_W-1:0]  r_s2_row;
    logic [COL_W-1:0]           r_s2_col;
    wsf_pkg::t_emit             r_s2_emit;

    always_comb begin
        shift       = i_s1_valid && i_s2_load;
        new_col.top = i_rd_data.upper;
        new_col.mid = i_rd_data.lower;
        new_col.bot = i_s1_px;
        n_sum = SUM_W'(r_win_a.top) + SUM_W'(r_win_a.mid) + SUM_W'(r_win_a.bot)
              + SUM_W'(r_win_b.top) + (SUM_W'(r_win_b.mid) << 1) + SUM_W'(r_win_b.bot)
              + SUM_W'(new_col.top) + SUM_W'(new_col.mid) + SUM_W'(new_col.bot);
    end

    // consecutive words hit different columns, so write-back never meets the next read
    assign o_wr_en         = shift;
    assign o_wr_addr       = i_s1_col;
    assign o_wr_data.upper = i_rd_data.lower;
    assign o_wr_data.lower = i_s1_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_a    <= '0;
            r_win_b    <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            if (shift) begin
                r_win_a <= r_win_b;
                r_win_b <= new_col;
            end
            if (i_s2_load) begin
                r_s2_valid <= i_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_s2_sum    <= n_sum;
            r_s2_center <= r_win_b.mid;
            r_s2_mid    <= new_col.mid;
            r_s2_px     <= i_s1_px;
            r_s2_row    <= i_s1_row;
            r_s2_col    <= i_s1_col;
            r_s2_emit   <= i_s1_emit;
        end
    end

    assign o_s2_valid  = r_s2_valid;
    assign o_s2_sum    = r_s2_sum;
    assign o_s2_center = r_s2_center;
    assign o_s2_mid    = r_s2_mid;
    assign o_s2_px     = r_s2_px;
    assign o_s2_row    = r_s2_row;
    assign o_s2_col    = r_s2_col;
    assign o_s2_emit   = r_s2_emit;

endmodule

// File: rtl/wsf_out.sv
// Divide by ten and result slots: up to three result words per pixel, sent in order.
// Depends on wsf_pkg.
module wsf_out #(
    parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s2_valid,
    input  logic [wsf_pkg::SUM_W-1:0]   i_s2_sum,
    input  logic [wsf_pkg::PIX_W-1:0]   i_s2_center,
    input  logic [wsf_pkg::PIX_W-1:0]   i_s2_mid,
    input  logic [wsf_pkg::PIX_W-1:0]   i_s2_px,
    input  logic [wsf_pkg::ROW_W-1:0]   i_s2_row,
    input  logic [COL_W-1:0]            i_s2_col,
    input  wsf_pkg::t_emit              i_s2_emit,
    input  logic                        i_out_stall,
    output logic                        o_take,
    output logic                        o_out_valid,
    output logic [wsf_pkg::PIX_W-1:0]   o_pixel_out,
    output logic [wsf_pkg::ROW_W-1:0]   o_out_row,
    output logic [COL_W-1:0]            o_out_col,
    output logic                        o_run_last,
    output logic                        o_frame_done
);

    localparam int PROD_W = wsf_pkg::SUM_W + wsf_pkg::DIV10_MUL_W;

    typedef struct packed {
        logic [wsf_pkg::PIX_W-1:0] pix;
        logic [wsf_pkg::ROW_W-1:0] row;
        logic [COL_W-1:0]          col;
        logic                      done;
    } t_word;

    t_word                      r_slot [3];
    t_word                      n_slot [3];
    logic [2:0]                 r_mask;
    logic [2:0]                 n_mask;
    logic [2:0]                 low_bit;
    t_word                      sel;
    logic                       single;
    logic                       pop;
    logic [PROD_W-1:0]          prod;
    logic [wsf_pkg::PIX_W-1:0]  quot;
    logic [wsf_pkg::ROW_W-1:0]  row_up;

    always_comb begin
        prod   = PROD_W'(i_s2_sum) * PROD_W'(wsf_pkg::DIV10_MUL);
        quot   = prod[wsf_pkg::DIV10_SHIFT +: wsf_pkg::PIX_W];
        row_up = i_s2_row - 1'b1;

        n_slot[0].pix  = i_s2_emit.filt ? quot : i_s2_center;
        n_slot[0].row  = row_up;
        n_slot[0].col  = i_s2_col - 1'b1;
        n_slot[0].done = 1'b0;
        n_slot[1].pix  = i_s2_mid;
        n_slot[1].row  = row_up;
        n_slot[1].col  = i_s2_col;
        n_slot[1].done = 1'b0;
        n_slot[2].pix  = i_s2_px;
        n_slot[2].row  = i_s2_row;
        n_slot[2].col  = i_s2_col;
        n_slot[2].done = i_s2_emit.done;
        n_mask = {i_s2_emit.res_c, i_s2_emit.res_b, i_s2_emit.res_a};

        if (r_mask[0]) begin
            sel     = r_slot[0];
            low_bit = 3'b001;
        end else if (r_mask[1]) begin
            sel     = r_slot[1];
            low_bit = 3'b010;
        end else begin
            sel     = r_slot[2];
            low_bit = 3'b100;
        end

        single = (r_mask == 3'b001) || (r_mask == 3'b010) || (r_mask == 3'b100);
        pop    = (r_mask != 3'b000) && !i_out_stall;
        o_take = (r_mask == 3'b000) || (single && !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (o_take) begin
            r_mask <= i_s2_valid ? n_mask : 3'b000;
        end else if (pop) begin
            r_mask <= r_mask & ~low_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_s2_valid) begin
            r_slot <= n_slot;
        end
    end

    assign o_out_valid  = (r_mask != 3'b000);
    assign o_pixel_out  = sel.pix;
    assign o_out_row    = sel.row;
    assign o_out_col    = sel.col;
    assign o_run_last   = single;
    assign o_frame_done = sel.done;

endmodule

// File: rtl/weighted_3x3_smoothing_filter.sv
// Smoothing filter top; built from wsf_ctrl, wsf_line_mem, wsf_window, wsf_out and wsf_pkg.
// A taken pixel passes the stage-one and stage-two registers and the result slots to the output.
// Throughput: one pixel per cycle unless stalled, set by the single result port: two words for
// row ends after the first row and for last-row pixels past column 0, three for the final pixel.
// Synchronous reset clears position, window and valids, loads a 1024 x 1024 frame size;
// the line stores are not cleared.
`include "weighted_3x3_smoothing_filter_assert.svh"
module weighted_3x3_smoothing_filter #(
    parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wsf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wsf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [wsf_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [wsf_pkg::PIX_W-1:0]     o_pixel_out,
    output logic [wsf_pkg::ROW_W-1:0]     o_out_row,
    output logic [COL_W-1:0]              o_out_col,
    output logic                          o_run_last,
    output logic                          o_frame_done
);

    logic                       accept;
    logic                       s1_go;
    logic                       s2_go;
    logic                       take;

    logic [COL_W-1:0]           rd_addr;
    wsf_pkg::t_line             rd_data;
    logic                       wr_en;
    logic [COL_W-1:0]           wr_addr;
    wsf_pkg::t_line             wr_data;

    logic                       s1_valid;
    logic [wsf_pkg::PIX_W-1:0]  s1_px;
    logic [wsf_pkg::ROW_W-1:0]  s1_row;
    logic [COL_W-1:0]           s1_col;
    wsf_pkg::t_emit             s1_emit;

    logic                       s2_valid;
    logic [wsf_pkg::SUM_W-1:0]  s2_sum;
    logic [wsf_pkg::PIX_W-1:0]  s2_center;
    logic [wsf_pkg::PIX_W-1:0]  s2_mid;
    logic [wsf_pkg::PIX_W-1:0]  s2_px;
    logic [wsf_pkg::ROW_W-1:0]  s2_row;
    logic [COL_W-1:0]           s2_col;
    wsf_pkg::t_emit             s2_emit;

    assign s2_go      = !s2_valid || take;
    assign s1_go      = !s1_valid || s2_go;
    assign accept     = i_in_valid && s1_go;
    assign o_in_stall = !s1_go;

    wsf_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_s1_load  (s1_go),
        .i_pixel    (i_pixel_in),
        .o_rd_addr  (rd_addr),
        .o_s1_valid (s1_valid),
        .o_s1_px    (s1_px),
        .o_s1_row   (s1_row),
        .o_s1_col   (s1_col),
        .o_s1_emit  (s1_emit)
    );

    wsf_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    wsf_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s2_load   (s2_go),
        .i_s1_valid  (s1_valid),
        .i_s1_px     (s1_px),
        .i_s1_row    (s1_row),
        .i_s1_col    (s1_col),
        .i_s1_emit   (s1_emit),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_s2_valid  (s2_valid),
        .o_s2_sum    (s2_sum),
        .o_s2_center (s2_center),
        .o_s2_mid    (s2_mid),
        .o_s2_px     (s2_px),
        .o_s2_row    (s2_row),
        .o_s2_col    (s2_col),
        .o_s2_emit   (s2_emit)
    );

    wsf_out #(.MAX_WIDTH(MAX_WIDTH)) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s2_valid   (s2_valid),
        .i_s2_sum     (s2_sum),
        .i_s2_center  (s2_center),
        .i_s2_mid     (s2_mid),
        .i_s2_px      (s2_px),
        .i_s2_row     (s2_row),
        .i_s2_col     (s2_col),
        .i_s2_emit    (s2_emit),
        .i_out_stall  (i_out_stall),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .o_pixel_out  (o_pixel_out),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

    `WSF_ASSERT_IMPL(a_line_rw_apart, i_clk, i_rst_n, accept && wr_en, rd_addr != wr_addr)
    `WSF_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, accept, s1_valid)
    `WSF_ASSERT_IMPL(a_done_is_last, i_clk, i_rst_n, o_out_valid && o_frame_done, o_run_last)
    `WSF_ASSERT_NEXT(a_hold_when_stalled, i_clk, i_rst_n, s1_valid && !s2_go, s1_valid && $stable(s1_col))

endmodule
